[hw/rtl/w2s_pkg.sv]
// Shared constants, register codes and arithmetic helpers for the projection unit.
package w2s_pkg;

  localparam int COORD_W = 32;
  localparam int PT_W    = 32;
  localparam int AXC_W   = 16;
  localparam int AXIS_W  = 3 * AXC_W;
  localparam int SC_W    = 24;
  localparam int SCR_W   = 32;
  localparam int CFG_W   = 48;
  localparam int D_W     = COORD_W + 1;
  localparam int PROD_W  = D_W + AXC_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int MAG_W   = SUM_W - 1;
  localparam int MLO_W   = MAG_W / 2;
  localparam int MHI_W   = MAG_W - MLO_W;
  localparam int NUM_W   = MAG_W + SC_W;
  localparam int DEN_W   = SUM_W;
  localparam int QB      = SCR_W + 1;
  localparam int NST     = QB + 8;

  localparam logic [SCR_W-1:0] HALF_Q16      = SCR_W'(32768);
  localparam logic [SCR_W-1:0] MINUS_ONE_Q16 = SCR_W'(-65536);
  localparam logic [SCR_W-1:0] SAT_MAX       = {1'b0, {(SCR_W-1){1'b1}}};
  localparam logic [SCR_W-1:0] SAT_MIN       = {1'b1, {(SCR_W-1){1'b0}}};
  localparam logic [QB-1:0]    POS_LIM       = QB'(SAT_MAX) - QB'(HALF_Q16);
  localparam logic [QB-1:0]    NEG_LIM       = QB'(SAT_MIN) + QB'(HALF_Q16);

  typedef enum logic [2:0] {
    CFG_CAM_X   = 3'd0,
    CFG_CAM_Y   = 3'd1,
    CFG_CAM_Z   = 3'd2,
    CFG_FORWARD = 3'd3,
    CFG_RIGHT   = 3'd4,
    CFG_UP      = 3'd5,
    CFG_SCALE_X = 3'd6,
    CFG_SCALE_Y = 3'd7
  } cfg_idx_e;

  // One restoring division step: {quotient bit, new remainder}.
  function automatic logic [DEN_W:0] div_step(input logic [DEN_W-1:0] rem,
                                               input logic bit_in,
                                               input logic [DEN_W-1:0] den);
    logic [DEN_W:0] t;
    logic           ge;
    logic [DEN_W:0] r;
    t  = {rem, bit_in};
    ge = (t >= {1'b0, den});
    r  = ge ? (t - {1'b0, den}) : t;
    return {ge, r[DEN_W-1:0]};
  endfunction

endpackage

[hw/rtl/world_to_screen_projection_unit.sv]
// Pinhole projection of world points to normalized screen coordinates.
//
// One point enters per clock, and its result is offered on the output from the
// output register. The path has 41 register stages: seven for the camera
// offset, dot products, magnitudes, scaling and divider setup, QB (33)
// restoring divider stages with one quotient bit each, and one output stage.
// Throughput is one point per cycle. The whole pipeline holds while the result
// transfer is stalled.
module world_to_screen_projection_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [2:0]                  cfg_idx_i,
  input  logic [w2s_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // point_x, point_y, point_z
  input  logic [3*w2s_pkg::PT_W-1:0]  s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // screen_x, screen_y
  output logic [2*w2s_pkg::SCR_W-1:0] m_axis_tdata,
  // in_front
  output logic                        m_axis_tuser
);
  import w2s_pkg::*;

  logic [COORD_W-1:0] cam_q [3];
  logic [AXIS_W-1:0]  axis_q [3];
  logic [SC_W-1:0]    scale_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_q[0]   <= '0;
      cam_q[1]   <= '0;
      cam_q[2]   <= '0;
      axis_q[0]  <= AXIS_W'(48'd16384);
      axis_q[1]  <= AXIS_W'(48'd1073741824);
      axis_q[2]  <= AXIS_W'(48'd268435456000);
      scale_q[0] <= SC_W'(65536);
      scale_q[1] <= SC_W'(65536);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CAM_X:   cam_q[0]   <= cfg_data_i[COORD_W-1:0];
        CFG_CAM_Y:   cam_q[1]   <= cfg_data_i[COORD_W-1:0];
        CFG_CAM_Z:   cam_q[2]   <= cfg_data_i[COORD_W-1:0];
        CFG_FORWARD: axis_q[0]  <= cfg_data_i[AXIS_W-1:0];
        CFG_RIGHT:   axis_q[1]  <= cfg_data_i[AXIS_W-1:0];
        CFG_UP:      axis_q[2]  <= cfg_data_i[AXIS_W-1:0];
        CFG_SCALE_X: scale_q[0] <= cfg_data_i[SC_W-1:0];
        CFG_SCALE_Y: scale_q[1] <= cfg_data_i[SC_W-1:0];
        default: ;
      endcase
    end
  end

  logic [NST-1:0] v_q;
  logic           en;

  assign en            = !v_q[NST-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = v_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NST-2:0], s_axis_tvalid};
    end
  end

  logic signed [D_W-1:0]    d_q [3];
  logic signed [PROD_W-1:0] prod_q [3][3];
  logic signed [SUM_W-1:0]  sum_q [3];
  logic                     front_q [QB+4];
  logic                     neg_q [QB+4][2];
  logic [MAG_W-1:0]         mag_q [2];
  logic [DEN_W-1:0]         den_q [QB+3];
  logic [MLO_W+SC_W-1:0]    pl_q [2];
  logic [MHI_W+SC_W-1:0]    ph_q [2];
  logic [NUM_W-1:0]         num_q [2];
  logic                     ovf_q [QB+1][2];
  logic [DEN_W-1:0]         rem_q [QB+1][2];
  logic [QB-1:0]            lo_q [QB+1][2];
  logic [QB-1:0]            quo_q [QB+1][2];
  logic [SCR_W-1:0]         sx_q, sy_q;
  logic                     fo_q;

  function automatic logic [SCR_W-1:0] finish(input logic [QB-1:0] q, input logic ovf,
                                              input logic neg);
    logic [QB:0] v;
    if (!neg) begin
      v = {1'b0, q} + (QB+1)'(HALF_Q16);
      return (ovf || q > POS_LIM) ? SAT_MAX : v[SCR_W-1:0];
    end
    v = (QB+1)'(HALF_Q16) - {1'b0, q};
    return (ovf || q > NEG_LIM) ? SAT_MIN : v[SCR_W-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        d_q[k] <= D_W'($signed(s_axis_tdata[k*PT_W +: COORD_W]))
                - D_W'($signed(cam_q[k]));
      end
      for (int a = 0; a < 3; a++) begin
        for (int k = 0; k < 3; k++) begin
          prod_q[a][k] <= d_q[k] * $signed(axis_q[a][k*AXC_W +: AXC_W]);
        end
      end
      for (int a = 0; a < 3; a++) begin
        sum_q[a] <= SUM_W'(prod_q[a][0]) + SUM_W'(prod_q[a][1]) + SUM_W'(prod_q[a][2]);
      end
      front_q[0]  <= (sum_q[0] > 0);
      neg_q[0][0] <= sum_q[1][SUM_W-1];
      neg_q[0][1] <= (sum_q[2] > 0);
      mag_q[0]    <= sum_q[1][SUM_W-1] ? MAG_W'(-sum_q[1]) : MAG_W'(sum_q[1]);
      mag_q[1]    <= sum_q[2][SUM_W-1] ? MAG_W'(-sum_q[2]) : MAG_W'(sum_q[2]);
      den_q[0]    <= {sum_q[0][SUM_W-2:0], 1'b0};
      for (int c = 0; c < 2; c++) begin
        pl_q[c]  <= mag_q[c][MLO_W-1:0] * scale_q[c];
        ph_q[c]  <= mag_q[c][MAG_W-1:MLO_W] * scale_q[c];
        num_q[c] <= NUM_W'(pl_q[c]) + (NUM_W'(ph_q[c]) << MLO_W);
        ovf_q[0][c] <= (num_q[c][NUM_W-1:QB] >= den_q[2]);
        rem_q[0][c] <= DEN_W'(num_q[c] >> QB);
        lo_q[0][c]  <= num_q[c][QB-1:0];
        quo_q[0][c] <= '0;
      end
      for (int s = 1; s < QB + 3; s++) begin
        den_q[s] <= den_q[s-1];
      end
      for (int s = 1; s < QB + 4; s++) begin
        front_q[s] <= front_q[s-1];
        neg_q[s]   <= neg_q[s-1];
      end
      for (int s = 0; s < QB; s++) begin
        for (int c = 0; c < 2; c++) begin
          logic [DEN_W:0] st;
          st = div_step(rem_q[s][c], lo_q[s][c][QB-1], den_q[s+3]);
          rem_q[s+1][c] <= st[DEN_W-1:0];
          lo_q[s+1][c]  <= {lo_q[s][c][QB-2:0], 1'b0};
          quo_q[s+1][c] <= {quo_q[s][c][QB-2:0], st[DEN_W]};
          ovf_q[s+1][c] <= ovf_q[s][c];
        end
      end
      fo_q <= front_q[QB+3];
      sx_q <= front_q[QB+3] ? finish(quo_q[QB][0], ovf_q[QB][0], neg_q[QB+3][0])
                            : MINUS_ONE_Q16;
      sy_q <= front_q[QB+3] ? finish(quo_q[QB][1], ovf_q[QB][1], neg_q[QB+3][1])
                            : MINUS_ONE_Q16;
    end
  end

  assign m_axis_tdata = {sy_q, sx_q};
  assign m_axis_tuser = fo_q;

endmodule
